// ----- hw/rtl/ert_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_pkg
// Shared types and constants of the echo reply tracker.
// ----------------------------------------------------------------------------
package ert_pkg;

   // Depth of the seen bitmap; slots are taken modulo this power of two.
   localparam int DUP_WINDOW = 1024;

   localparam logic [1:0] VERDICT_NOT_ECHO  = 2'd0;
   localparam logic [1:0] VERDICT_OUR_ECHO  = 2'd1;
   localparam logic [1:0] VERDICT_NOT_OURS  = 2'd2;
   localparam logic [1:0] VERDICT_TX_DONE   = 2'd3;

   localparam logic       CMD_SENT          = 1'b0;
   localparam logic       CMD_RECEIVED      = 1'b1;

   localparam logic       CSR_DATA_LENGTH   = 1'b0;
   localparam logic       CSR_OUR_ID        = 1'b1;

   localparam logic [7:0]  ECHO_REPLY_TYPE  = 8'd0;
   localparam logic [17:0] ICMP_HEAD_BYTES  = 18'd8;
   localparam logic [17:0] IP_HEAD_BYTES    = 18'd20;
   localparam logic [17:0] STAMP_BYTES      = 18'd16;
   localparam logic [15:0] DATA_LENGTH_RST  = 16'd56;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_step;   // clear one bitmap slot after reset
      logic capture;      // register the accepted item
      logic read_slot;    // read the bitmap slot of the item
      logic execute;      // update state and form the result
   } ert_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
   } ert_status_type;

endpackage

// ----- hw/rtl/echo_reply_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_reply_tracker_core
// Tracks echo requests and replies with duplicate detection and timing.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// req_      in         req_valid / req_stall
// rsp_      out        rsp_valid / rsp_stall
// csr_      in         csr_write, no handshake
//
// The result becomes valid after the bitmap read and then the update that
// follow the input transfer. The result is held until taken and req_stall
// stays high meanwhile, so a new item is taken only after the last result
// is taken. After reset the bitmap is cleared one slot a cycle, with
// req_stall high until every slot is cleared.
// Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module echo_reply_tracker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [3:0]  req_header_words,
   input  logic [15:0] req_packet_length,
   input  logic [7:0]  req_message_type,
   input  logic [15:0] req_message_id,
   input  logic [15:0] req_sequence_in,
   input  logic [31:0] req_trip_time_us,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_is_duplicate,
   output logic        rsp_wrong_length,
   output logic [15:0] rsp_sequence_out,
   output logic [31:0] rsp_sent_count,
   output logic [31:0] rsp_received_count,
   output logic [31:0] rsp_repeat_count,
   output logic [31:0] rsp_rtt_min,
   output logic [31:0] rsp_rtt_max,
   output logic [47:0] rsp_rtt_sum,
   output logic [63:0] rsp_rtt_square_sum
);
   import ert_pkg::*;

   ert_cmd_type    cmd;
   ert_status_type status;

   ert_control u_control (
      .clock     (clock),
      .reset     (reset),
      .status    (status),
      .cmd       (cmd),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   ert_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_command        (req_command),
      .req_header_words   (req_header_words),
      .req_packet_length  (req_packet_length),
      .req_message_type   (req_message_type),
      .req_message_id     (req_message_id),
      .req_sequence_in    (req_sequence_in),
      .req_trip_time_us   (req_trip_time_us),
      .rsp_verdict        (rsp_verdict),
      .rsp_is_duplicate   (rsp_is_duplicate),
      .rsp_wrong_length   (rsp_wrong_length),
      .rsp_sequence_out   (rsp_sequence_out),
      .rsp_sent_count     (rsp_sent_count),
      .rsp_received_count (rsp_received_count),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_rtt_min        (rsp_rtt_min),
      .rsp_rtt_max        (rsp_rtt_max),
      .rsp_rtt_sum        (rsp_rtt_sum),
      .rsp_rtt_square_sum (rsp_rtt_square_sum)
   );

endmodule

// ----- hw/rtl/ert_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_datapath
// Seen bitmap, counters, timing statistics and result register.
// ----------------------------------------------------------------------------
module ert_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  ert_pkg::ert_cmd_type cmd,
   output ert_pkg::ert_status_type status,
   input  logic                 csr_write,
   input  logic                 csr_index,
   input  logic [15:0]          csr_data,
   input  logic                 req_command,
   input  logic [3:0]           req_header_words,
   input  logic [15:0]          req_packet_length,
   input  logic [7:0]           req_message_type,
   input  logic [15:0]          req_message_id,
   input  logic [15:0]          req_sequence_in,
   input  logic [31:0]          req_trip_time_us,
   output logic [1:0]           rsp_verdict,
   output logic                 rsp_is_duplicate,
   output logic                 rsp_wrong_length,
   output logic [15:0]          rsp_sequence_out,
   output logic [31:0]          rsp_sent_count,
   output logic [31:0]          rsp_received_count,
   output logic [31:0]          rsp_repeat_count,
   output logic [31:0]          rsp_rtt_min,
   output logic [31:0]          rsp_rtt_max,
   output logic [47:0]          rsp_rtt_sum,
   output logic [63:0]          rsp_rtt_square_sum
);
   import ert_pkg::*;

   localparam int SLOT_BITS = $clog2(DUP_WINDOW);

   logic                 seen_mem [DUP_WINDOW];
   logic                 seen_rd_ff;
   logic [SLOT_BITS:0]   clear_ff;
   logic [SLOT_BITS:0]   clear_in;

   logic [15:0] data_length_ff;
   logic [15:0] our_id_ff;
   logic        timing_on_ff;

   logic        cmd_ff;
   logic [3:0]  hwords_ff;
   logic [15:0] plen_ff;
   logic [7:0]  mtype_ff;
   logic [15:0] mid_ff;
   logic [15:0] seq_ff;
   logic [31:0] trip_ff;
   logic [63:0] square_ff;

   logic [31:0] sent_ff, received_ff, repeat_ff, min_ff, max_ff;
   logic [47:0] sum_ff;
   logic [63:0] sq_sum_ff;

   logic [SLOT_BITS-1:0] slot;
   logic [17:0] hlen;
   logic [17:0] payload;
   logic        is_short, is_echo, is_ours;
   logic [1:0]  verdict;
   logic        do_timing;
   logic [48:0] sum_wide;
   logic [64:0] sq_wide;

   assign slot     = (cmd_ff == CMD_SENT) ? sent_ff[SLOT_BITS-1:0] : seq_ff[SLOT_BITS-1:0];
   assign hlen     = {12'd0, hwords_ff, 2'b00};
   assign payload  = {2'b00, plen_ff} - hlen - ICMP_HEAD_BYTES;
   assign is_short = {2'b00, plen_ff} < hlen + ICMP_HEAD_BYTES;
   assign is_echo  = mtype_ff == ECHO_REPLY_TYPE;
   assign is_ours  = mid_ff == our_id_ff;
   assign do_timing = timing_on_ff && (payload >= STAMP_BYTES);
   assign sum_wide = {1'b0, sum_ff} + {17'd0, trip_ff};
   assign sq_wide  = {1'b0, sq_sum_ff} + {1'b0, square_ff};

   always_comb begin
      if (cmd_ff == CMD_SENT) begin
         verdict = VERDICT_TX_DONE;
      end else if (is_short) begin
         verdict = VERDICT_NOT_OURS;
      end else if (!is_echo) begin
         verdict = VERDICT_NOT_ECHO;
      end else if (!is_ours) begin
         verdict = VERDICT_NOT_OURS;
      end else begin
         verdict = VERDICT_OUR_ECHO;
      end
   end

   assign clear_in = clear_ff + 1'b1;
   assign status.clear_done = clear_ff[SLOT_BITS];

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         seen_mem[clear_ff[SLOT_BITS-1:0]] <= 1'b0;
      end else if (cmd.execute) begin
         if (verdict == VERDICT_TX_DONE) begin
            seen_mem[slot] <= 1'b0;
         end else if (verdict == VERDICT_OUR_ECHO) begin
            seen_mem[slot] <= 1'b1;
         end
      end
      if (cmd.read_slot) begin
         seen_rd_ff <= seen_mem[slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         hwords_ff <= req_header_words;
         plen_ff   <= req_packet_length;
         mtype_ff  <= req_message_type;
         mid_ff    <= req_message_id;
         seq_ff    <= req_sequence_in;
         trip_ff   <= req_trip_time_us;
      end
      if (cmd.read_slot) begin
         square_ff <= {32'd0, trip_ff} * {32'd0, trip_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff       <= '0;
         data_length_ff <= DATA_LENGTH_RST;
         our_id_ff      <= '0;
         timing_on_ff   <= 1'b1;
         sent_ff        <= '0;
         received_ff    <= '0;
         repeat_ff      <= '0;
         min_ff         <= '1;
         max_ff         <= '0;
         sum_ff         <= '0;
         sq_sum_ff      <= '0;
      end else begin
         if (cmd.clear_step) begin
            clear_ff <= clear_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               CSR_DATA_LENGTH: begin
                  data_length_ff <= csr_data;
                  timing_on_ff   <= {2'b00, csr_data} >= STAMP_BYTES;
               end
               CSR_OUR_ID: our_id_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.execute) begin
            if (verdict == VERDICT_TX_DONE) begin
               if (sent_ff != '1) sent_ff <= sent_ff + 1'b1;
            end else if (verdict == VERDICT_OUR_ECHO) begin
               if (seen_rd_ff) begin
                  if (repeat_ff != '1) repeat_ff <= repeat_ff + 1'b1;
               end else if (received_ff != '1) begin
                  received_ff <= received_ff + 1'b1;
               end
               if (timing_on_ff && !do_timing) timing_on_ff <= 1'b0;
               if (do_timing) begin
                  sum_ff    <= sum_wide[48] ? '1 : sum_wide[47:0];
                  sq_sum_ff <= sq_wide[64] ? '1 : sq_wide[63:0];
                  if (trip_ff < min_ff) min_ff <= trip_ff;
                  if (trip_ff > max_ff) max_ff <= trip_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_verdict      <= verdict;
         rsp_is_duplicate <= (verdict == VERDICT_OUR_ECHO) && seen_rd_ff;
         rsp_wrong_length <= (verdict == VERDICT_OUR_ECHO) &&
                             ({2'b00, plen_ff} !=
                              {2'b00, data_length_ff} + ICMP_HEAD_BYTES + IP_HEAD_BYTES);
         rsp_sequence_out <= (verdict == VERDICT_TX_DONE) ? sent_ff[15:0] : 16'd0;
      end
   end

   assign rsp_sent_count     = sent_ff;
   assign rsp_received_count = received_ff;
   assign rsp_repeat_count   = repeat_ff;
   assign rsp_rtt_min        = min_ff;
   assign rsp_rtt_max        = max_ff;
   assign rsp_rtt_sum        = sum_ff;
   assign rsp_rtt_square_sum = sq_sum_ff;

`ifndef SYNTHESIS
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      (max_ff != '0) |-> (min_ff <= max_ff))
      else $error("rtt minimum above maximum");
   a_sent_mono: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset)) |-> (sent_ff >= $past(sent_ff)))
      else $error("sent count went down");
   a_clear_stops: assert property (@(posedge clock) disable iff (reset)
      status.clear_done |-> !cmd.clear_step)
      else $error("bitmap clear ran past its end");
`endif

endmodule

// ----- hw/rtl/ert_control.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ert_control
// Controller sequencing bitmap clear, capture, read, update and result.
// ----------------------------------------------------------------------------
module ert_control (
   input  logic                    clock,
   input  logic                    reset,
   input  ert_pkg::ert_status_type status,
   output ert_pkg::ert_cmd_type    cmd,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall
);
   import ert_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_SHOW
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_done) state_in = ST_IDLE;
            else cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            if (req_take) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_slot = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_valid_in_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_SHOW))
      else $error("result valid outside result state");
   a_exec_then_show: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> rsp_valid_ff)
      else $error("result not raised after update");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !rsp_valid_ff)
      else $error("item taken while a result waits");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the echo reply tracker core. Directed and random
// transmit and receive transfers are driven with random gaps and result
// stalls. A behavioural tracker in the scoreboard predicts every result,
// and each result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
   import ert_pkg::*;

   localparam int WINDOW    = DUP_WINDOW;
   localparam int MAX_QUIET = 20000;

   typedef struct {
      logic [1:0]  verdict;
      logic        dup;
      logic        wrong;
      logic [15:0] seq;
      logic [31:0] sent;
      logic [31:0] rcvd;
      logic [31:0] rpt;
      logic [31:0] tmin;
      logic [31:0] tmax;
      logic [47:0] tsum;
      logic [63:0] tsq;
   } reply_type;

   class echo_scoreboard;
      bit          seen[WINDOW];
      logic [31:0] sent_total, rcvd_total, rpt_total, tmin, tmax;
      logic [47:0] tsum;
      logic [63:0] tsq;
      logic [15:0] data_len, my_id;
      bit          timing;
      reply_type   pending[$];
      int          errors;

      function void clear();
         foreach (seen[i]) seen[i] = 0;
         sent_total = 0; rcvd_total = 0; rpt_total = 0;
         tmin = '1; tmax = 0; tsum = 0; tsq = 0;
         data_len = DATA_LENGTH_RST; my_id = 0; timing = 1;
         errors = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] v);
         if (idx == CSR_DATA_LENGTH) begin
            data_len = v;
            timing = (v >= 16);
         end else begin
            my_id = v;
         end
      endfunction

      function void note_request(logic cmd, logic [3:0] hw, logic [15:0] plen,
                                 logic [7:0] mt, logic [15:0] mid,
                                 logic [15:0] sq, logic [31:0] trip);
         reply_type r;
         logic [17:0] hlen;
         logic [48:0] s48;
         logic [64:0] s64;
         r = '{default: '0};
         hlen = 18'(hw) * 18'd4;
         if (cmd == CMD_SENT) begin
            r.seq = sent_total[15:0];
            seen[sent_total % WINDOW] = 0;
            if (sent_total != '1) sent_total++;
            r.verdict = VERDICT_TX_DONE;
         end else if (18'(plen) < hlen + 8) begin
            r.verdict = VERDICT_NOT_OURS;
         end else if (mt != ECHO_REPLY_TYPE) begin
            r.verdict = VERDICT_NOT_ECHO;
         end else if (mid != my_id) begin
            r.verdict = VERDICT_NOT_OURS;
         end else begin
            if (timing) begin
               if (18'(plen) - hlen - 8 >= 16) begin
                  s48 = 49'(tsum) + 49'(trip);
                  tsum = s48[48] ? '1 : s48[47:0];
                  s64 = 65'(tsq) + 65'(64'(trip) * 64'(trip));
                  tsq = s64[64] ? '1 : s64[63:0];
                  if (trip < tmin) tmin = trip;
                  if (trip > tmax) tmax = trip;
               end else begin
                  timing = 0;
               end
            end
            if (seen[sq % WINDOW]) begin
               if (rpt_total != '1) rpt_total++;
               r.dup = 1;
            end else begin
               seen[sq % WINDOW] = 1;
               if (rcvd_total != '1) rcvd_total++;
            end
            r.wrong = (18'(plen) != 18'(data_len) + 28);
            r.verdict = VERDICT_OUR_ECHO;
         end
         r.sent = sent_total; r.rcvd = rcvd_total; r.rpt = rpt_total;
         r.tmin = tmin; r.tmax = tmax; r.tsum = tsum; r.tsq = tsq;
         pending.push_back(r);
      endfunction

      function void check_reply(reply_type a);
         reply_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, verdict %0d", $realtime, a.verdict);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.verdict != e.verdict) report("verdict", e.verdict, a.verdict);
         if (a.dup != e.dup) report("is_duplicate", e.dup, a.dup);
         if (a.wrong != e.wrong) report("wrong_length", e.wrong, a.wrong);
         if (a.seq != e.seq) report("sequence_out", e.seq, a.seq);
         if (a.sent != e.sent) report("sent_count", e.sent, a.sent);
         if (a.rcvd != e.rcvd) report("received_count", e.rcvd, a.rcvd);
         if (a.rpt != e.rpt) report("repeat_count", e.rpt, a.rpt);
         if (a.tmin != e.tmin) report("rtt_min", e.tmin, a.tmin);
         if (a.tmax != e.tmax) report("rtt_max", e.tmax, a.tmax);
         if (a.tsum != e.tsum) report("rtt_sum", e.tsum, a.tsum);
         if (a.tsq != e.tsq) report("rtt_square_sum", e.tsq, a.tsq);
      endfunction

      function void report(string f, logic [63:0] e, logic [63:0] a);
         $display("%0t: %s expected %0h actual %0h", $realtime, f, e, a);
         errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic        csr_index = 0;
   logic [15:0] csr_data = 0;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_command = 0;
   logic [3:0]  req_header_words = 0;
   logic [15:0] req_packet_length = 0;
   logic [7:0]  req_message_type = 0;
   logic [15:0] req_message_id = 0;
   logic [15:0] req_sequence_in = 0;
   logic [31:0] req_trip_time_us = 0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   logic [1:0]  rsp_verdict;
   logic        rsp_is_duplicate, rsp_wrong_length;
   logic [15:0] rsp_sequence_out;
   logic [31:0] rsp_sent_count, rsp_received_count, rsp_repeat_count;
   logic [31:0] rsp_rtt_min, rsp_rtt_max;
   logic [47:0] rsp_rtt_sum;
   logic [63:0] rsp_rtt_square_sum;

   echo_scoreboard tracker = new();
   int  quiet_cycles = 0;
   logic [15:0] cur_id = 0;
   logic [15:0] cur_len = DATA_LENGTH_RST;

   echo_reply_tracker_core i_dut (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= MAX_QUIET) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_reply('{rsp_verdict, rsp_is_duplicate, rsp_wrong_length,
            rsp_sequence_out, rsp_sent_count, rsp_received_count, rsp_repeat_count,
            rsp_rtt_min, rsp_rtt_max, rsp_rtt_sum, rsp_rtt_square_sum});
   end

   // Result side: a random stall before each transfer, sometimes none.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
      end
   end

   task automatic write_reg(logic idx, logic [15:0] v);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      tracker.write_reg(idx, v);
      if (idx == CSR_OUR_ID) cur_id = v; else cur_len = v;
      @(posedge clock);
   endtask

   task automatic send_item(logic cmd, logic [3:0] hw, logic [15:0] plen,
                            logic [7:0] mt, logic [15:0] mid, logic [15:0] sq,
                            logic [31:0] trip, bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd; req_header_words <= hw; req_packet_length <= plen;
      req_message_type <= mt; req_message_id <= mid; req_sequence_in <= sq;
      req_trip_time_us <= trip;
      @(posedge clock iff !req_stall);
      tracker.note_request(cmd, hw, plen, mt, mid, sq, trip);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock iff tracker.pending.size() == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic send_reply(logic [31:0] trip, bit burst);
      logic [3:0] hw;
      logic [15:0] plen;
      logic [15:0] sq;
      hw = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
      plen = ($urandom_range(0, 2) == 0) ? 16'($urandom) : cur_len + 16'd28;
      sq = ($urandom_range(0, 1) == 0) ? tracker.sent_total[15:0] - 16'($urandom_range(1, 40))
                                       : 16'($urandom);
      send_item(CMD_RECEIVED, hw, plen, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'd0,
                ($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_id, sq, trip, burst);
   endtask

   initial begin
      int n;
      bit burst;
      tracker.clear();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_reg(CSR_OUR_ID, 16'h1234);

      // Directed: transmits, replies, duplicates, extremes, short and foreign.
      for (int i = 0; i < 4; i++)
         send_item(CMD_SENT, '1, '1, '1, '1, '1, '1, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'h1234, 0, 100, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'h1234, 0, 50, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'h1234, 16'd1025, '1, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'h1234, 1, '1, 0);
      send_item(CMD_RECEIVED, 5, 83, 0, 16'h1234, 2, 0, 0);
      send_item(CMD_RECEIVED, 15, 67, 0, 16'h1234, 3, 7, 0);
      send_item(CMD_RECEIVED, 15, 68, 0, 16'h1234, 3, 7, 0);
      send_item(CMD_RECEIVED, 5, 84, 8, 16'h1234, 3, 7, 0);
      send_item(CMD_RECEIVED, 5, 84, 8'hff, 16'h1234, 3, 7, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'hedcb, 3, 7, 0);
      send_item(CMD_RECEIVED, 0, 0, 0, 0, 0, 0, 0);
      send_item(CMD_RECEIVED, 0, '1, 0, 16'h1234, '1, 9, 0);
      send_item(CMD_RECEIVED, 5, 40, 0, 16'h1234, 4, 9, 0);
      send_item(CMD_RECEIVED, 5, 84, 0, 16'h1234, 5, 9, 0);
      drain();

      write_reg(CSR_DATA_LENGTH, 16'd65507);
      write_reg(CSR_OUR_ID, 16'hffff);
      send_item(CMD_RECEIVED, 5, '1, 0, '1, 6, '1, 0);
      send_item(CMD_RECEIVED, 5, 16'd65535, 0, '1, 7, '1, 0);
      drain();
      write_reg(CSR_DATA_LENGTH, 16'd0);
      write_reg(CSR_OUR_ID, 16'd0);
      send_item(CMD_RECEIVED, 5, 28, 0, 0, 8, 1, 0);
      drain();

      // Random phases, each with a fresh setting.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_reg(CSR_DATA_LENGTH, 16'd56);
            1: write_reg(CSR_DATA_LENGTH, 16'd15);
            2: write_reg(CSR_DATA_LENGTH, 16'd16);
            default: write_reg(CSR_DATA_LENGTH, 16'($urandom_range(0, 1500)));
         endcase
         write_reg(CSR_OUR_ID, 16'($urandom));
         n = 0;
         while (n < 185) begin
            burst = (n % 60) < 15;
            if ($urandom_range(0, 2) == 0)
               send_item(CMD_SENT, 4'($urandom), 16'($urandom), 8'($urandom),
                         16'($urandom), 16'($urandom), $urandom, burst);
            else
               send_reply(($urandom_range(0, 9) == 0) ? $urandom
                          : $urandom_range(0, 100000), burst);
            n++;
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
